/* rtl/touch_region_hit_tester_assert.svh */
// ----------------------------------------------------------------------------
// touch region hit tester assertion macros
// shared assertion forms, sampled on clk and disabled during rst
// ----------------------------------------------------------------------------
`ifndef TOUCH_REGION_HIT_TESTER_ASSERT_SVH
`define TOUCH_REGION_HIT_TESTER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define TRH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define TRH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/trh_pkg.sv */
// ----------------------------------------------------------------------------
// trh_pkg
// types, codes and reset values shared by the touch region hit tester
// ----------------------------------------------------------------------------
`default_nettype none

package trh_pkg;

  localparam int unsigned NUM_REGIONS_DEF = 16;
  localparam int unsigned IDX_W           = 6;   // slot index, covers up to 64 regions
  localparam int unsigned COORD_W         = 10;
  localparam int unsigned RAW_W           = 12;
  localparam int unsigned LEVEL_W         = 4;
  localparam int unsigned PROD_W          = 28;

  localparam logic [LEVEL_W-1:0] MAX_LEVEL = 4'd15;

  // item operations
  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_CLEAR  = 3'd2;
  localparam logic [2:0] OP_PAUSE  = 3'd3;
  localparam logic [2:0] OP_RESUME = 3'd4;
  localparam logic [2:0] OP_TOUCH  = 3'd5;

  // result kinds
  localparam logic [2:0] KIND_NONE    = 3'd0;
  localparam logic [2:0] KIND_ADDED   = 3'd1;
  localparam logic [2:0] KIND_FULL    = 3'd2;
  localparam logic [2:0] KIND_PRESS   = 3'd3;
  localparam logic [2:0] KIND_RELEASE = 3'd4;

  // digitizer event codes
  localparam logic [4:0] EV_ABS        = 5'd3;
  localparam logic [5:0] CODE_X        = 6'd0;
  localparam logic [5:0] CODE_Y        = 6'd1;
  localparam logic [5:0] CODE_PRESSURE = 6'd24;

  // register indexes
  localparam logic [2:0] REG_DEAD_BAND   = 3'd0;
  localparam logic [2:0] REG_PRESS_LEVEL = 3'd1;
  localparam logic [2:0] REG_Y_ORIGIN    = 3'd2;
  localparam logic [2:0] REG_X_SCALE     = 3'd3;
  localparam logic [2:0] REG_Y_SCALE     = 3'd4;

  // register reset values
  localparam logic [11:0] DEAD_BAND_RST   = 12'd10;
  localparam logic [11:0] PRESS_LEVEL_RST = 12'd50;
  localparam logic [9:0]  Y_ORIGIN_RST    = 10'd240;
  localparam logic [15:0] X_SCALE_RST     = 16'd20972;
  localparam logic [15:0] Y_SCALE_RST     = 16'd15729;

  // command held for the whole sweep and seen by every cell
  typedef struct packed {
    logic [2:0]         op;
    logic [COORD_W-1:0] rect_left;
    logic [COORD_W-1:0] rect_top;
    logic [COORD_W-1:0] rect_width;
    logic [COORD_W-1:0] rect_height;
    logic [3:0]         slot_number;
    logic [4:0]         event_type;
    logic [5:0]         event_code;
    logic [RAW_W-1:0]   event_value;
  } cmd_t;

  // running result handed from cell to cell
  typedef struct packed {
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic             hit_any;
    logic             hit_multi;
    logic [IDX_W-1:0] hit_first;
    logic [IDX_W-1:0] hit_last;
  } carry_t;

endpackage

`default_nettype wire

/* rtl/trh_point.sv */
// ----------------------------------------------------------------------------
// trh_point
// dead band filter and Q0.16 scaling of the raw X and Y samples
// ----------------------------------------------------------------------------
`default_nettype none

module trh_point (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            mul_en,
  input  wire logic                            upd_en,
  input  wire trh_pkg::cmd_t                   cmd,
  input  wire logic [11:0]                     dead_band,
  input  wire logic [9:0]                      y_origin,
  input  wire logic [15:0]                     x_scale_q16,
  input  wire logic [15:0]                     y_scale_q16,
  output logic [trh_pkg::RAW_W-1:0]            point_x,
  output logic signed [12:0]                   point_y
);

  logic [trh_pkg::PROD_W-1:0] prod;
  logic [trh_pkg::RAW_W-1:0]  last_raw_x;
  logic [trh_pkg::RAW_W-1:0]  last_raw_y;
  logic [trh_pkg::RAW_W-1:0]  diff_x;
  logic [trh_pkg::RAW_W-1:0]  diff_y;
  logic [15:0]                scale;
  logic                       is_abs;
  logic                       moved_x;
  logic                       moved_y;
  logic signed [12:0]         y_mirror;

  assign scale = (cmd.event_code == trh_pkg::CODE_Y) ? y_scale_q16 : x_scale_q16;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= trh_pkg::PROD_W'(cmd.event_value * scale);
    end
  end

  assign diff_x = (cmd.event_value > last_raw_x) ? cmd.event_value - last_raw_x
                                                 : last_raw_x - cmd.event_value;
  assign diff_y = (cmd.event_value > last_raw_y) ? cmd.event_value - last_raw_y
                                                 : last_raw_y - cmd.event_value;
  assign moved_x = diff_x > dead_band;
  assign moved_y = diff_y > dead_band;
  assign is_abs  = cmd.event_type == trh_pkg::EV_ABS;
  assign y_mirror = $signed({3'b000, y_origin}) - $signed({1'b0, prod[27:16]});

  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw_x <= '0;
      last_raw_y <= '0;
      point_x    <= '0;
      point_y    <= '0;
    end else if (upd_en && is_abs) begin
      if (cmd.event_code == trh_pkg::CODE_X && moved_x) begin
        point_x    <= prod[27:16];
        last_raw_x <= cmd.event_value;
      end
      if (cmd.event_code == trh_pkg::CODE_Y && moved_y) begin
        point_y    <= y_mirror;
        last_raw_y <= cmd.event_value;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/trh_cell.sv */
// ----------------------------------------------------------------------------
// trh_cell
// one table slot: rectangle, enable count and its step of the token sweep
// ----------------------------------------------------------------------------
`default_nettype none

module trh_cell #(
  parameter int unsigned IDX = 0
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire trh_pkg::cmd_t                 cmd,
  input  wire logic [trh_pkg::RAW_W-1:0]     point_x,
  input  wire logic signed [12:0]            point_y,
  input  wire logic                          tok_in,
  input  wire trh_pkg::carry_t               carry_in,
  output logic                               tok_out,
  output trh_pkg::carry_t                    carry_out
);

  localparam logic [trh_pkg::IDX_W-1:0] MY_IDX = IDX[trh_pkg::IDX_W-1:0];

  logic [trh_pkg::COORD_W-1:0] left;
  logic [trh_pkg::COORD_W-1:0] top;
  logic [trh_pkg::COORD_W-1:0] wide;
  logic [trh_pkg::COORD_W-1:0] tall;
  logic [trh_pkg::LEVEL_W-1:0] level;
  logic [trh_pkg::LEVEL_W-1:0] level_next;
  logic [trh_pkg::COORD_W:0]   right;
  logic [trh_pkg::COORD_W:0]   bottom;
  logic                        hit;
  logic                        take_free;
  trh_pkg::carry_t             carry_next;

  assign right  = {1'b0, left} + {1'b0, wide};
  assign bottom = {1'b0, top} + {1'b0, tall};

  // strict containment, only for slots enabled exactly once
  assign hit = (level == 4'd1) &&
               (point_x > {2'b00, left}) && (point_x < {1'b0, right}) &&
               (point_y > $signed({3'b000, top})) && (point_y < $signed({2'b00, bottom}));

  assign take_free = (cmd.op == trh_pkg::OP_ADD) && (level == '0) && !carry_in.free_found;

  always_comb begin
    carry_next = carry_in;
    if (take_free) begin
      carry_next.free_found = 1'b1;
      carry_next.free_idx   = MY_IDX;
    end
    if (hit) begin
      if (!carry_in.hit_any) begin
        carry_next.hit_any   = 1'b1;
        carry_next.hit_first = MY_IDX;
      end else begin
        carry_next.hit_multi = 1'b1;
      end
      carry_next.hit_last = MY_IDX;
    end
  end

  always_comb begin
    level_next = level;
    unique case (cmd.op)
      trh_pkg::OP_ADD: begin
        if (take_free) level_next = 4'd1;
      end
      trh_pkg::OP_REMOVE: begin
        if ({2'b00, cmd.slot_number} == MY_IDX) level_next = '0;
      end
      trh_pkg::OP_CLEAR: begin
        level_next = '0;
      end
      trh_pkg::OP_PAUSE: begin
        if (level != '0 && level != trh_pkg::MAX_LEVEL) level_next = level + 4'd1;
      end
      trh_pkg::OP_RESUME: begin
        if (level != '0) level_next = level - 4'd1;
      end
      default: begin
        level_next = level;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level   <= '0;
      tok_out <= 1'b0;
    end else begin
      tok_out <= tok_in;
      if (tok_in) level <= level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_in) carry_out <= carry_next;
    if (tok_in && take_free) begin
      left <= cmd.rect_left;
      top  <= cmd.rect_top;
      wide <= cmd.rect_width;
      tall <= cmd.rect_height;
    end
  end

endmodule

`default_nettype wire

/* rtl/touch_region_hit_tester.sv */
// an item runs through the multiply, point update, sweep and done states before its result
// reaches m_axis, and s_axis_tready stays low until idle; the sweep token walks the cell row
// one cell per cycle, starting in the point update stage that follows a multiply stage
// a finished result waits in the output register while the next item is accepted
// reset (rst, synchronous): enable counts, point, highlight and registers to defaults;
// rectangle stores are not cleared and need no clearing pass
// ----------------------------------------------------------------------------
// touch_region_hit_tester
// table of touch rectangles with nesting enables and a digitizer hit tester
// ----------------------------------------------------------------------------
`default_nettype none

`include "touch_region_hit_tester_assert.svh"

module touch_region_hit_tester #(
  parameter int unsigned NUM_REGIONS = trh_pkg::NUM_REGIONS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // rect_left, rect_top, rect_width, rect_height, slot_number, event_type,
  // event_code, event_value, zero fill
  input  wire logic [71:0] s_axis_tdata,
  // op
  input  wire logic [2:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // region_slot, point_x_out, point_y_out, zero fill
  output logic [31:0]      m_axis_tdata,
  // result_kind
  output logic [2:0]       m_axis_tuser
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_UPD   = 3'd2;
  localparam logic [2:0] S_SWEEP = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]  state;
  logic [2:0]  state_next;

  logic [11:0] dead_band;
  logic [11:0] press_level;
  logic [9:0]  y_origin;
  logic [15:0] x_scale_q16;
  logic [15:0] y_scale_q16;

  trh_pkg::cmd_t cmd;
  trh_pkg::carry_t res;

  logic [trh_pkg::RAW_W-1:0]  point_x;
  logic signed [12:0]         point_y;
  logic [NUM_REGIONS:0]       tok;
  trh_pkg::carry_t            carry [NUM_REGIONS+1];

  logic                       hl_valid;
  logic [trh_pkg::IDX_W-1:0]  hl_idx;

  logic        out_valid;
  logic [2:0]  out_kind;
  logic [3:0]  out_slot;
  logic [11:0] out_px;
  logic [12:0] out_py;

  logic        accept;
  logic        out_free;
  logic        is_pressure;
  logic        changed;
  logic [2:0]  kind;
  logic [3:0]  slot;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dead_band   <= trh_pkg::DEAD_BAND_RST;
      press_level <= trh_pkg::PRESS_LEVEL_RST;
      y_origin    <= trh_pkg::Y_ORIGIN_RST;
      x_scale_q16 <= trh_pkg::X_SCALE_RST;
      y_scale_q16 <= trh_pkg::Y_SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        trh_pkg::REG_DEAD_BAND:   dead_band   <= cfg_data[11:0];
        trh_pkg::REG_PRESS_LEVEL: press_level <= cfg_data[11:0];
        trh_pkg::REG_Y_ORIGIN:    y_origin    <= cfg_data[9:0];
        trh_pkg::REG_X_SCALE:     x_scale_q16 <= cfg_data;
        trh_pkg::REG_Y_SCALE:     y_scale_q16 <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // input transaction
  assign s_axis_tready = state == S_IDLE;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd.op          <= s_axis_tuser;
      cmd.rect_left   <= s_axis_tdata[9:0];
      cmd.rect_top    <= s_axis_tdata[19:10];
      cmd.rect_width  <= s_axis_tdata[29:20];
      cmd.rect_height <= s_axis_tdata[39:30];
      cmd.slot_number <= s_axis_tdata[43:40];
      cmd.event_type  <= s_axis_tdata[48:44];
      cmd.event_code  <= s_axis_tdata[54:49];
      cmd.event_value <= s_axis_tdata[66:55];
    end
  end

  trh_point u_point (
    .clk         (clk),
    .rst         (rst),
    .mul_en      (state == S_MUL),
    .upd_en      (state == S_UPD && cmd.op == trh_pkg::OP_TOUCH),
    .cmd         (cmd),
    .dead_band   (dead_band),
    .y_origin    (y_origin),
    .x_scale_q16 (x_scale_q16),
    .y_scale_q16 (y_scale_q16),
    .point_x     (point_x),
    .point_y     (point_y)
  );

  // token launched into the first cell during the update stage
  assign tok[0]   = state == S_UPD;
  assign carry[0] = '0;

  for (genvar g = 0; g < NUM_REGIONS; g++) begin : g_cell
    trh_cell #(
      .IDX (g)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .point_x   (point_x),
      .point_y   (point_y),
      .tok_in    (tok[g]),
      .carry_in  (carry[g]),
      .tok_out   (tok[g+1]),
      .carry_out (carry[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (state == S_SWEEP && tok[NUM_REGIONS]) res <= carry[NUM_REGIONS];
  end

  assign out_free = !out_valid || m_axis_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept) state_next = S_MUL;
      S_MUL:   state_next = S_UPD;
      S_UPD:   state_next = S_SWEEP;
      S_SWEEP: if (tok[NUM_REGIONS]) state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // result of the finished sweep
  assign is_pressure = cmd.op == trh_pkg::OP_TOUCH && cmd.event_type == trh_pkg::EV_ABS &&
                       cmd.event_code == trh_pkg::CODE_PRESSURE;
  // a single hit on the slot already highlighted changes nothing
  assign changed = res.hit_any && (res.hit_multi || !hl_valid || hl_idx != res.hit_first);

  always_comb begin
    kind = trh_pkg::KIND_NONE;
    slot = '0;
    if (cmd.op == trh_pkg::OP_ADD) begin
      if (res.free_found) begin
        kind = trh_pkg::KIND_ADDED;
        slot = res.free_idx[3:0];
      end else begin
        kind = trh_pkg::KIND_FULL;
      end
    end else if (is_pressure) begin
      if (cmd.event_value == '0) begin
        if (res.hit_any) begin
          kind = trh_pkg::KIND_RELEASE;
          slot = res.hit_first[3:0];
        end
      end else if (cmd.event_value > press_level && changed) begin
        kind = trh_pkg::KIND_PRESS;
        slot = res.hit_last[3:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      hl_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
        if (cmd.op == trh_pkg::OP_PAUSE) begin
          hl_valid <= 1'b0;
        end else if (is_pressure) begin
          if (cmd.event_value == '0) begin
            hl_valid <= 1'b0;
          end else if (cmd.event_value > press_level && res.hit_any) begin
            hl_valid <= 1'b1;
          end
        end
      end else if (m_axis_tvalid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_kind <= kind;
      out_slot <= slot;
      out_px   <= point_x;
      out_py   <= point_y;
      if (is_pressure && cmd.event_value != '0 && cmd.event_value > press_level &&
          res.hit_any) begin
        hl_idx <= res.hit_last;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_kind;
  assign m_axis_tdata  = {3'b000, out_py, out_px, out_slot};

  `TRH_ASSERT_NOW(a_one_token, 1'b1, $countones(tok) <= 1, "more than one sweep token")
  `TRH_ASSERT_NOW(a_token_in_sweep, tok[NUM_REGIONS], state == S_SWEEP,
    "sweep token left the row outside the sweep state")
  `TRH_ASSERT_NEXT(a_accept_starts, accept, state == S_MUL && !s_axis_tready,
    "accepted transaction did not start the multiply stage")
  `TRH_ASSERT_NOW(a_hl_range, hl_valid, 32'(hl_idx) < NUM_REGIONS,
    "highlight slot beyond the table")

endmodule

`default_nettype wire

/* dv/touch_region_hit_tester_tb.sv */
// ----------------------------------------------------------------------------
// touch_region_hit_tester_tb
// drives table and digitizer items into the hit tester, predicts each report
// from a local copy of the region table, point and highlight, and checks every
// result transaction field by field; registers are rewritten between phases
// ----------------------------------------------------------------------------
`default_nettype none

module touch_region_hit_tester_tb;
  import trh_pkg::*;

  localparam int unsigned NUM_REGIONS = NUM_REGIONS_DEF;
  localparam int unsigned LATENCY     = NUM_REGIONS + 4;
  localparam int unsigned LONG_HOLD   = 300;
  localparam logic [2:0]  OP_SPARE_LO = 3'd6;
  localparam logic [2:0]  OP_SPARE_HI = 3'd7;

  typedef struct {
    logic [2:0]         kind;
    logic [3:0]         slot;
    logic [11:0]        x;
    logic signed [12:0] y;
  } region_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  touch_region_hit_tester #(
    .NUM_REGIONS (NUM_REGIONS)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow registers
  logic [11:0] dead_band   = DEAD_BAND_RST;
  logic [11:0] press_level = PRESS_LEVEL_RST;
  logic [9:0]  y_origin    = Y_ORIGIN_RST;
  logic [15:0] x_scale     = X_SCALE_RST;
  logic [15:0] y_scale     = Y_SCALE_RST;

  // shadow table and touch state
  logic [9:0]         rect_x0   [NUM_REGIONS] = '{default: '0};
  logic [9:0]         rect_y0   [NUM_REGIONS] = '{default: '0};
  logic [9:0]         rect_w    [NUM_REGIONS] = '{default: '0};
  logic [9:0]         rect_h    [NUM_REGIONS] = '{default: '0};
  logic [3:0]         nest_count[NUM_REGIONS] = '{default: '0};
  int                 slots_used = 0;
  logic [11:0]        raw_x_seen = '0;
  logic [11:0]        raw_y_seen = '0;
  logic [11:0]        cur_x = '0;
  logic signed [12:0] cur_y = '0;
  int                 lit_slot = -1;

  cmd_t           touch_cmd_queue[$];
  region_report_t expected_reports[$];
  cmd_t           cmd_on_bus;
  int             send_gap_max = 10;
  int             recv_gap_max = 10;
  int             send_wait = 0;
  int             recv_wait = 0;
  int             hold_kicks = 0;
  int             hold_seen = 0;
  int             hold_left = 0;
  int unsigned    fail_count = 0;

  function automatic bit beyond_band(logic [11:0] v, logic [11:0] last);
    int d;
    d = (v > last) ? int'(v) - int'(last) : int'(last) - int'(v);
    return d > int'(dead_band);
  endfunction

  // strict containment, only for slots at nesting level one
  function automatic bit region_hit(int j);
    int px, py;
    px = int'(cur_x);
    py = int'(cur_y);
    return nest_count[j] == 4'd1 &&
           px > int'(rect_x0[j]) && px < int'(rect_x0[j]) + int'(rect_w[j]) &&
           py > int'(rect_y0[j]) && py < int'(rect_y0[j]) + int'(rect_h[j]);
  endfunction

  function automatic region_report_t predict_report(cmd_t c);
    region_report_t r;
    int unsigned    prod;
    int             yv;
    bit             changed;
    r.kind = KIND_NONE;
    r.slot = '0;
    case (c.op)
      OP_ADD: begin
        r.kind = KIND_FULL;
        for (int i = 0; i < NUM_REGIONS; i++) begin
          if (nest_count[i] == 4'd0) begin
            rect_x0[i] = c.rect_left;
            rect_y0[i] = c.rect_top;
            rect_w[i] = c.rect_width;
            rect_h[i] = c.rect_height;
            nest_count[i] = 4'd1;
            if (slots_used < i + 1) slots_used = i + 1;
            r.kind = KIND_ADDED;
            r.slot = i[3:0];
            break;
          end
        end
      end
      OP_REMOVE: begin
        if (c.slot_number < NUM_REGIONS) nest_count[c.slot_number] = 4'd0;
      end
      OP_CLEAR: begin
        for (int i = 0; i < NUM_REGIONS; i++) nest_count[i] = 4'd0;
        slots_used = 0;
      end
      OP_PAUSE: begin
        lit_slot = -1;
        for (int i = 0; i < slots_used && i < NUM_REGIONS; i++)
          if (nest_count[i] > 4'd0 && nest_count[i] < MAX_LEVEL)
            nest_count[i] = nest_count[i] + 4'd1;
      end
      OP_RESUME: begin
        for (int i = 0; i < slots_used && i < NUM_REGIONS; i++)
          if (nest_count[i] > 4'd0) nest_count[i] = nest_count[i] - 4'd1;
      end
      OP_TOUCH: begin
        if (c.event_type == EV_ABS) begin
          if (c.event_code == CODE_X) begin
            if (beyond_band(c.event_value, raw_x_seen)) begin
              prod = 32'(c.event_value) * 32'(x_scale);
              cur_x = prod[27:16];
              raw_x_seen = c.event_value;
            end
          end else if (c.event_code == CODE_Y) begin
            if (beyond_band(c.event_value, raw_y_seen)) begin
              prod = 32'(c.event_value) * 32'(y_scale);
              yv = int'(y_origin) - int'(prod >> 16);
              cur_y = yv[12:0];
              raw_y_seen = c.event_value;
            end
          end else if (c.event_code == CODE_PRESSURE) begin
            if (c.event_value == '0) begin
              lit_slot = -1;
              for (int j = 0; j < slots_used && j < NUM_REGIONS; j++) begin
                if (region_hit(j)) begin
                  r.kind = KIND_RELEASE;
                  r.slot = j[3:0];
                  break;
                end
              end
            end else if (c.event_value > press_level) begin
              changed = 1'b0;
              for (int j = 0; j < slots_used && j < NUM_REGIONS; j++) begin
                if (region_hit(j) && lit_slot != j) begin
                  lit_slot = j;
                  changed = 1'b1;
                end
              end
              if (changed) begin
                r.kind = KIND_PRESS;
                r.slot = lit_slot[3:0];
              end
            end
          end
        end
      end
      default: ;
    endcase
    r.x = cur_x;
    r.y = cur_y;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, $signed(want), $signed(got));
      fail_count++;
    end
  endfunction

  // input side: one item per transaction, random gap after each accept
  always @(posedge clk) begin : item_driver
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_reports.push_back(predict_report(cmd_on_bus));
        send_wait = $urandom_range(0, send_gap_max);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_wait > 0) begin
          send_wait--;
          s_axis_tvalid <= 1'b0;
        end else if (touch_cmd_queue.size() > 0) begin
          cmd_on_bus = touch_cmd_queue.pop_front();
          s_axis_tdata <= {5'b0, cmd_on_bus.event_value, cmd_on_bus.event_code,
                           cmd_on_bus.event_type, cmd_on_bus.slot_number,
                           cmd_on_bus.rect_height, cmd_on_bus.rect_width,
                           cmd_on_bus.rect_top, cmd_on_bus.rect_left};
          s_axis_tuser <= cmd_on_bus.op;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, started by bumping hold_kicks
  always @(posedge clk) begin : hold_counter
    if (hold_kicks != hold_seen) begin
      hold_seen <= hold_kicks;
      hold_left <= LONG_HOLD;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin : report_monitor
    region_report_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_reports.size() == 0) begin
          $error("result transaction with no item pending");
          fail_count++;
        end else begin
          want = expected_reports.pop_front();
          check_field("result_kind", 32'(want.kind), 32'(m_axis_tuser));
          check_field("region_slot", 32'(want.slot), 32'(m_axis_tdata[3:0]));
          check_field("point_x_out", 32'(want.x), 32'(m_axis_tdata[15:4]));
          check_field("point_y_out", 32'(want.y), 32'($signed(m_axis_tdata[28:16])));
        end
        recv_wait = $urandom_range(0, recv_gap_max);
      end
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic cmd_t random_fields();
    cmd_t c;
    c.op = 3'($urandom_range(0, 7));
    c.rect_left = 10'($urandom_range(0, 1023));
    c.rect_top = 10'($urandom_range(0, 1023));
    c.rect_width = 10'($urandom_range(0, 1023));
    c.rect_height = 10'($urandom_range(0, 1023));
    c.slot_number = 4'($urandom_range(0, 15));
    c.event_type = 5'($urandom_range(0, 31));
    c.event_code = 6'($urandom_range(0, 63));
    c.event_value = 12'($urandom_range(0, 4095));
    return c;
  endfunction

  function automatic cmd_t op_cmd(logic [2:0] op);
    cmd_t c;
    c = random_fields();
    c.op = op;
    return c;
  endfunction

  function automatic cmd_t touch_cmd(logic [5:0] code, logic [11:0] value);
    cmd_t c;
    c = op_cmd(OP_TOUCH);
    c.event_type = EV_ABS;
    c.event_code = code;
    c.event_value = value;
    return c;
  endfunction

  function automatic cmd_t rect_cmd(logic [9:0] l, logic [9:0] t, logic [9:0] w,
                                    logic [9:0] h);
    cmd_t c;
    c = op_cmd(OP_ADD);
    c.rect_left = l;
    c.rect_top = t;
    c.rect_width = w;
    c.rect_height = h;
    return c;
  endfunction

  // mostly rectangles in the reachable part of the screen
  function automatic cmd_t random_rect_cmd();
    if ($urandom_range(0, 7) == 0) return op_cmd(OP_ADD);
    return rect_cmd(10'($urandom_range(0, 700)), 10'($urandom_range(0, 300)),
                    10'($urandom_range(1, 700)), 10'($urandom_range(1, 500)));
  endfunction

  function automatic cmd_t press_cmd();
    case ($urandom_range(0, 2))
      0:       return touch_cmd(CODE_PRESSURE, 12'($urandom_range(0, 100)));
      1:       return touch_cmd(CODE_PRESSURE, 12'($urandom_range(0, 4095)));
      default: return touch_cmd(CODE_PRESSURE, 12'($urandom_range(60, 4095)));
    endcase
  endfunction

  task automatic queue_random(int count);
    int   pushed;
    int   pick;
    int   n;
    cmd_t c;
    pushed = 0;
    while (pushed < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        // gesture: move, press one or more times, then usually release
        touch_cmd_queue.push_back(touch_cmd(CODE_X, 12'($urandom_range(0, 4095))));
        touch_cmd_queue.push_back(touch_cmd(CODE_Y, 12'($urandom_range(0, 1200))));
        n = $urandom_range(1, 3);
        repeat (n) begin
          if ($urandom_range(0, 1) == 0)
            touch_cmd_queue.push_back(touch_cmd(CODE_X, 12'($urandom_range(0, 4095))));
          touch_cmd_queue.push_back(touch_cmd(CODE_PRESSURE,
                                              12'($urandom_range(60, 4095))));
          pushed += 2;
        end
        if ($urandom_range(0, 3) != 0) begin
          touch_cmd_queue.push_back(touch_cmd(CODE_PRESSURE, 12'd0));
          pushed++;
        end
        pushed += 2;
      end else if (pick < 55) begin
        touch_cmd_queue.push_back(random_rect_cmd());
        pushed++;
      end else if (pick < 62) begin
        touch_cmd_queue.push_back(op_cmd(OP_REMOVE));
        pushed++;
      end else if (pick < 65) begin
        touch_cmd_queue.push_back(op_cmd(OP_CLEAR));
        pushed++;
      end else if (pick < 70) begin
        touch_cmd_queue.push_back(op_cmd(OP_PAUSE));
        pushed++;
      end else if (pick < 75) begin
        touch_cmd_queue.push_back(op_cmd(OP_RESUME));
        pushed++;
      end else if (pick < 77) begin
        // deep nesting toward saturation, then as many resumes
        n = $urandom_range(13, 16);
        repeat (n) touch_cmd_queue.push_back(op_cmd(OP_PAUSE));
        repeat (n) touch_cmd_queue.push_back(op_cmd(OP_RESUME));
        pushed += 2 * n;
      end else if (pick < 79) begin
        // enough adds to run out of slots
        repeat (NUM_REGIONS + 1) touch_cmd_queue.push_back(random_rect_cmd());
        pushed += NUM_REGIONS + 1;
      end else if (pick < 90) begin
        case ($urandom_range(0, 2))
          0:       c = touch_cmd(CODE_X, 12'($urandom_range(0, 4095)));
          1:       c = touch_cmd(CODE_Y, 12'($urandom_range(0, 4095)));
          default: c = press_cmd();
        endcase
        touch_cmd_queue.push_back(c);
        pushed++;
      end else begin
        c = random_fields();
        if ($urandom_range(0, 1) == 0) c.op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        else c.op = OP_TOUCH;
        touch_cmd_queue.push_back(c);
        pushed++;
      end
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (touch_cmd_queue.size() != 0 || s_axis_tvalid || expected_reports.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_DEAD_BAND:   dead_band = value[11:0];
      REG_PRESS_LEVEL: press_level = value[11:0];
      REG_Y_ORIGIN:    y_origin = value[9:0];
      REG_X_SCALE:     x_scale = value;
      REG_Y_SCALE:     y_scale = value;
      default: ;
    endcase
  endtask

  task automatic write_settings(int db, int pl, int yo, int xs, int ys);
    write_reg(REG_DEAD_BAND, db[15:0]);
    write_reg(REG_PRESS_LEVEL, pl[15:0]);
    write_reg(REG_Y_ORIGIN, yo[15:0]);
    write_reg(REG_X_SCALE, xs[15:0]);
    write_reg(REG_Y_SCALE, ys[15:0]);
    @(negedge clk);
  endtask

  initial begin : stimulus
    cmd_t c;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed pass at reset settings
    touch_cmd_queue.push_back(rect_cmd(10'd200, 10'd50, 10'd200, 10'd100));
    touch_cmd_queue.push_back(rect_cmd(10'd1023, 10'd1023, 10'd1023, 10'd1023));
    touch_cmd_queue.push_back(rect_cmd(10'd0, 10'd0, 10'd0, 10'd0));
    touch_cmd_queue.push_back(touch_cmd(CODE_X, 12'd1000));
    touch_cmd_queue.push_back(touch_cmd(CODE_X, 12'd1005));     // inside dead band
    touch_cmd_queue.push_back(touch_cmd(CODE_Y, 12'd500));
    touch_cmd_queue.push_back(touch_cmd(CODE_PRESSURE, 12'd4095));
    touch_cmd_queue.push_back(touch_cmd(CODE_PRESSURE, 12'd51));  // same highlight again
    touch_cmd_queue.push_back(touch_cmd(CODE_PRESSURE, 12'd50));  // light press
    touch_cmd_queue.push_back(touch_cmd(CODE_PRESSURE, 12'd0));
    touch_cmd_queue.push_back(op_cmd(OP_PAUSE));
    touch_cmd_queue.push_back(touch_cmd(CODE_PRESSURE, 12'd4095));
    touch_cmd_queue.push_back(touch_cmd(CODE_PRESSURE, 12'd0));   // release miss
    touch_cmd_queue.push_back(op_cmd(OP_RESUME));
    c = op_cmd(OP_REMOVE);
    c.slot_number = 4'hf;
    touch_cmd_queue.push_back(c);
    c.slot_number = 4'h0;
    touch_cmd_queue.push_back(c);
    touch_cmd_queue.push_back(touch_cmd(CODE_PRESSURE, 12'd0));
    c = touch_cmd(CODE_X, 12'd4095);
    c.event_type = 5'd0;                                           // not absolute
    touch_cmd_queue.push_back(c);
    touch_cmd_queue.push_back(touch_cmd(6'h3f, 12'hfff));           // unknown code
    c = '1;
    c.op = OP_SPARE_LO;
    touch_cmd_queue.push_back(c);
    c.op = OP_SPARE_HI;
    touch_cmd_queue.push_back(c);
    touch_cmd_queue.push_back(touch_cmd(CODE_Y, 12'd4095));
    touch_cmd_queue.push_back(touch_cmd(CODE_X, 12'd4095));
    touch_cmd_queue.push_back(touch_cmd(CODE_X, 12'd0));
    touch_cmd_queue.push_back(op_cmd(OP_CLEAR));
    wait_drained();

    queue_random(150);
    wait_drained();

    write_settings(0, 0, 0, 65535, 65535);
    queue_random(100);
    wait_drained();

    write_settings(4095, 4095, 1023, 0, 0);
    queue_random(40);
    wait_drained();

    // receiver holds off while the sender keeps offering back to back
    write_settings($urandom_range(0, 40), $urandom_range(0, 300), $urandom_range(300, 1023),
                   $urandom_range(8000, 40000), $urandom_range(8000, 40000));
    send_gap_max = 0;
    hold_kicks++;
    queue_random(60);
    wait_drained();

    // no idling on either side
    write_settings(DEAD_BAND_RST, PRESS_LEVEL_RST, Y_ORIGIN_RST, X_SCALE_RST, Y_SCALE_RST);
    recv_gap_max = 0;
    queue_random(150);
    wait_drained();

    repeat (2 * LATENCY) @(posedge clk);
    if (expected_reports.size() != 0) begin
      $error("%0d results never arrived", expected_reports.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #3000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
